@@ rtl/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types, sizes and codes for the stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

    // Storage sizes
    localparam int DSTACK_DEPTH = 256;
    localparam int RSTACK_DEPTH = 64;
    localparam int MEM_WORDS    = 256;

    localparam int DS_IDX_W  = (DSTACK_DEPTH > 1) ? $clog2(DSTACK_DEPTH) : 1;
    localparam int DS_CNT_W  = $clog2(DSTACK_DEPTH + 1);
    localparam int RS_IDX_W  = (RSTACK_DEPTH > 1) ? $clog2(RSTACK_DEPTH) : 1;
    localparam int RS_CNT_W  = $clog2(RSTACK_DEPTH + 1);
    localparam int MEM_IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    // Opcodes
    localparam logic [7:0] OP_HALT  = 8'd0;
    localparam logic [7:0] OP_PUSH  = 8'd1;
    localparam logic [7:0] OP_POP   = 8'd2;
    localparam logic [7:0] OP_DUP   = 8'd3;
    localparam logic [7:0] OP_ADD   = 8'd4;
    localparam logic [7:0] OP_SUB   = 8'd5;
    localparam logic [7:0] OP_MUL   = 8'd6;
    localparam logic [7:0] OP_DIV   = 8'd7;
    localparam logic [7:0] OP_CMP   = 8'd8;
    localparam logic [7:0] OP_JMP   = 8'd9;
    localparam logic [7:0] OP_JZ    = 8'd10;
    localparam logic [7:0] OP_JNZ   = 8'd11;
    localparam logic [7:0] OP_STW   = 8'd12;
    localparam logic [7:0] OP_LOAD  = 8'd13;
    localparam logic [7:0] OP_CALL  = 8'd14;
    localparam logic [7:0] OP_RET   = 8'd15;
    localparam logic [7:0] OP_SWAP  = 8'd16;

    // Status codes
    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_HALTED     = 4'd1,
        ST_DS_OVER    = 4'd2,
        ST_DS_UNDER   = 4'd3,
        ST_RS_OVER    = 4'd4,
        ST_RS_UNDER   = 4'd5,
        ST_OPD_END    = 4'd6,
        ST_BAD_TARGET = 4'd7,
        ST_DIV_ZERO   = 4'd8,
        ST_BAD_INDEX  = 4'd9,
        ST_BAD_OPCODE = 4'd10,
        ST_PC_RANGE   = 4'd11,
        ST_STOPPED    = 4'd12
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_DIV
    } fsm_t;

    // Divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/sme_ram.sv @@
// ----------------------------------------------------------------------------
// sme_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sme_divider.sv @@
// ----------------------------------------------------------------------------
// sme_divider
// Signed 32-bit divider, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sme_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  sme_pkg::div_req_t req,
    output sme_pkg::div_rsp_t rsp
);
    import sme_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [32:0] trial;
    logic [32:0] diff;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        diff  = trial - {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
            den_next  = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
            neg_next  = req.dividend[31] ^ req.divisor[31];
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

@@ rtl/stack_machine_executor.sv @@
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack-machine instruction per input word against RAM stacks.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_*       in         instruction word: func, operand
//  m_*       out        result word: next_pc, status, top_value, stack_depth,
//                       running
//  APB       in/out     register 0 program_length
//
// An instruction goes from FSM_IDLE to FSM_EXEC: the accept edge reads the stack,
// return stack and word memory RAMs, the edge that leaves FSM_EXEC writes back
// and loads the result; a divide instead waits in FSM_DIV for the bit-serial divider.
// Reset clears counters, the program counter and word-memory valid bits at once.
// A new word is taken only when the result register is empty or being drained.
// ----------------------------------------------------------------------------
module stack_machine_executor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[7:0], operand[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // next_pc[15:0], status[19:16], top_value[51:20],
                                   // stack_depth[60:52], running[61], zero[63:62]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sme_pkg::*;

    fsm_t                 state_reg, state_next;
    logic [15:0]          plen_reg;
    logic [15:0]          pc_reg, pc_next;
    logic                 run_reg, run_next;
    logic [DS_CNT_W-1:0]  depth_reg, depth_next;
    logic [RS_CNT_W-1:0]  rdepth_reg, rdepth_next;
    logic [31:0]          tos_reg, tos_next;
    logic [7:0]           func_reg;
    logic [31:0]          opd_reg;
    logic [MEM_WORDS-1:0] wvalid_reg;
    logic                 wvalid_rd_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [63:0]          m_tdata_reg;

    logic                 accept;
    logic                 finish;
    logic                 div_start;
    status_t              status;
    logic [16:0]          pc_plus1;
    logic [16:0]          pc_plus5;
    logic                 has_opd;
    logic                 bad_tgt;
    logic                 bad_idx;
    logic                 take;
    logic [15:0]          npc_seq;
    logic [31:0]          alu_res;
    logic [31:0]          ds_rd;
    logic [31:0]          wm_rd;
    logic [15:0]          rs_rd;
    logic                 upd;
    logic                 ds_we;
    logic [DS_IDX_W-1:0]  ds_waddr;
    logic [31:0]          ds_wdata;
    logic [DS_IDX_W-1:0]  ds_raddr;
    logic [DS_CNT_W-1:0]  depth_m1;
    logic [DS_CNT_W-1:0]  depth_m2;
    logic                 wm_we;
    logic [MEM_IDX_W-1:0] wm_idx;
    logic                 rs_we;
    logic [RS_CNT_W-1:0]  rdepth_m1;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {16'd0, plen_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            plen_reg <= pwdata[15:0];
        end
    end

    // Handshakes
    assign s_tready = (state_reg == FSM_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: if (accept) state_next = FSM_EXEC;
            FSM_EXEC: state_next = div_start ? FSM_DIV : FSM_IDLE;
            FSM_DIV:  if (div_rsp.done) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        div_start = 1'b0;
        finish    = 1'b0;
        unique case (state_reg)
            FSM_IDLE: ;
            FSM_EXEC:
            begin
                div_start = (func_reg == OP_DIV) && (status == ST_OK);
                finish    = !div_start;
            end
            FSM_DIV:  finish = div_rsp.done;
            default:  ;
        endcase
    end

    // RAMs: read at accept, write back at finish
    assign depth_m1  = depth_reg - DS_CNT_W'(1);
    assign depth_m2  = depth_reg - DS_CNT_W'(2);
    assign ds_raddr  = depth_m2[DS_IDX_W-1:0];
    assign rdepth_m1 = rdepth_reg - RS_CNT_W'(1);
    assign wm_idx    = opd_reg[MEM_IDX_W-1:0];

    sme_ram #(.WIDTH(32), .DEPTH(DSTACK_DEPTH)) u_dstack (
        .clk   (clk),
        .we    (ds_we),
        .waddr (ds_waddr),
        .wdata (ds_wdata),
        .re    (accept),
        .raddr (ds_raddr),
        .rdata (ds_rd)
    );

    sme_ram #(.WIDTH(16), .DEPTH(RSTACK_DEPTH)) u_rstack (
        .clk   (clk),
        .we    (rs_we),
        .waddr (rdepth_reg[RS_IDX_W-1:0]),
        .wdata (npc_seq),
        .re    (accept),
        .raddr (rdepth_m1[RS_IDX_W-1:0]),
        .rdata (rs_rd)
    );

    sme_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_wmem (
        .clk   (clk),
        .we    (wm_we),
        .waddr (wm_idx),
        .wdata (tos_reg),
        .re    (accept),
        .raddr (s_tdata[8 +: MEM_IDX_W]),
        .rdata (wm_rd)
    );

    // Divider
    assign div_req.start    = div_start;
    assign div_req.dividend = ds_rd;
    assign div_req.divisor  = tos_reg;

    sme_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Bound checks
    assign pc_plus1 = {1'b0, pc_reg} + 17'd1;
    assign pc_plus5 = {1'b0, pc_reg} + 17'd5;
    assign has_opd  = (func_reg == OP_PUSH) || ((func_reg >= OP_JMP) && (func_reg <= OP_CALL));
    assign npc_seq  = has_opd ? pc_plus5[15:0] : pc_plus1[15:0];
    assign bad_tgt  = opd_reg[31] || (opd_reg >= {16'd0, plen_reg});
    assign bad_idx  = opd_reg[31] || (opd_reg >= 32'(MEM_WORDS));
    assign take     = (func_reg == OP_JZ) ? (tos_reg == 32'd0) : (tos_reg != 32'd0);

    // Status decode
    always_comb
    begin
        status = ST_OK;
        if (!run_reg)
        begin
            status = ST_STOPPED;
        end
        else if (pc_reg >= plen_reg)
        begin
            status = ST_PC_RANGE;
        end
        else if (has_opd && (pc_plus5 > {1'b0, plen_reg}))
        begin
            status = ST_OPD_END;
        end
        else
        begin
            unique case (func_reg)
                OP_HALT:  status = ST_HALTED;
                OP_PUSH:  if (depth_reg == DS_CNT_W'(DSTACK_DEPTH)) status = ST_DS_OVER;
                OP_POP:   if (depth_reg == '0) status = ST_DS_UNDER;
                OP_DUP:
                begin
                    if (depth_reg == '0) status = ST_DS_UNDER;
                    else if (depth_reg == DS_CNT_W'(DSTACK_DEPTH)) status = ST_DS_OVER;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_CMP, OP_SWAP:
                    if (depth_reg < DS_CNT_W'(2)) status = ST_DS_UNDER;
                OP_DIV:
                begin
                    if (depth_reg < DS_CNT_W'(2)) status = ST_DS_UNDER;
                    else if (tos_reg == 32'd0) status = ST_DIV_ZERO;
                end
                OP_JMP:   if (bad_tgt) status = ST_BAD_TARGET;
                OP_JZ, OP_JNZ:
                begin
                    if (depth_reg == '0) status = ST_DS_UNDER;
                    else if (take && bad_tgt) status = ST_BAD_TARGET;
                end
                OP_STW:
                begin
                    if (depth_reg == '0) status = ST_DS_UNDER;
                    else if (bad_idx) status = ST_BAD_INDEX;
                end
                OP_LOAD:
                begin
                    if (bad_idx) status = ST_BAD_INDEX;
                    else if (depth_reg == DS_CNT_W'(DSTACK_DEPTH)) status = ST_DS_OVER;
                end
                OP_CALL:
                begin
                    if (bad_tgt) status = ST_BAD_TARGET;
                    else if (rdepth_reg == RS_CNT_W'(RSTACK_DEPTH)) status = ST_RS_OVER;
                end
                OP_RET:   if (rdepth_reg == '0) status = ST_RS_UNDER;
                default:  status = ST_BAD_OPCODE;
            endcase
        end
    end

    // Arithmetic, a below b on the stack
    always_comb
    begin
        case (func_reg)
            OP_ADD:  alu_res = ds_rd + tos_reg;
            OP_SUB:  alu_res = ds_rd - tos_reg;
            OP_MUL:  alu_res = ds_rd * tos_reg;
            OP_DIV:  alu_res = div_rsp.quotient;
            default: alu_res = {31'd0, ($signed(ds_rd) < $signed(tos_reg))};
        endcase
    end

    // Write-back of the stacks, memory and counters
    assign upd = finish && (status == ST_OK);

    always_comb
    begin
        pc_next     = pc_reg;
        run_next    = run_reg;
        depth_next  = depth_reg;
        rdepth_next = rdepth_reg;
        tos_next    = tos_reg;
        ds_we       = 1'b0;
        ds_waddr    = depth_m1[DS_IDX_W-1:0];
        ds_wdata    = tos_reg;
        wm_we       = 1'b0;
        rs_we       = 1'b0;
        if (finish && (status != ST_OK))
        begin
            run_next = 1'b0;
            if (status == ST_HALTED)
            begin
                pc_next = pc_plus1[15:0];
            end
        end
        if (upd)
        begin
            pc_next = npc_seq;
            case (func_reg)
                OP_PUSH, OP_LOAD:
                begin
                    ds_we      = (depth_reg != '0);
                    tos_next   = (func_reg == OP_PUSH) ? opd_reg :
                                 (wvalid_rd_reg ? wm_rd : 32'd0);
                    depth_next = depth_reg + DS_CNT_W'(1);
                end
                OP_DUP:
                begin
                    ds_we      = 1'b1;
                    depth_next = depth_reg + DS_CNT_W'(1);
                end
                OP_POP:
                begin
                    tos_next   = ds_rd;
                    depth_next = depth_m1;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP:
                begin
                    tos_next   = alu_res;
                    depth_next = depth_m1;
                end
                OP_JMP:   pc_next = opd_reg[15:0];
                OP_JZ, OP_JNZ:
                begin
                    tos_next   = ds_rd;
                    depth_next = depth_m1;
                    if (take) pc_next = opd_reg[15:0];
                end
                OP_STW:
                begin
                    wm_we      = 1'b1;
                    tos_next   = ds_rd;
                    depth_next = depth_m1;
                end
                OP_CALL:
                begin
                    rs_we       = 1'b1;
                    rdepth_next = rdepth_reg + RS_CNT_W'(1);
                    pc_next     = opd_reg[15:0];
                end
                OP_RET:
                begin
                    rdepth_next = rdepth_m1;
                    pc_next     = rs_rd;
                end
                OP_SWAP:
                begin
                    ds_we    = 1'b1;
                    ds_waddr = depth_m2[DS_IDX_W-1:0];
                    tos_next = ds_rd;
                end
                default: ;
            endcase
        end
    end

    // Result register handshake
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (finish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_IDLE;
            pc_reg       <= '0;
            run_reg      <= 1'b1;
            depth_reg    <= '0;
            rdepth_reg   <= '0;
            wvalid_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            run_reg      <= run_next;
            depth_reg    <= depth_next;
            rdepth_reg   <= rdepth_next;
            m_tvalid_reg <= m_tvalid_next;
            if (wm_we)
            begin
                wvalid_reg[wm_idx] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (accept)
        begin
            func_reg      <= s_tdata[7:0];
            opd_reg       <= s_tdata[39:8];
            wvalid_rd_reg <= wvalid_reg[s_tdata[8 +: MEM_IDX_W]];
        end
        if (finish)
        begin
            m_tdata_reg <= {2'b00, run_next, 9'(depth_next),
                            (depth_next != '0) ? tos_next : 32'd0,
                            status, pc_next};
        end
    end

`ifndef ASSERT_OFF
    // A stopped block stays stopped.
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |=> !run_reg)
        else $error("run flag set again after stop");

    // Stack depth stays within the stack RAM.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DS_CNT_W'(DSTACK_DEPTH))
        else $error("data stack depth beyond capacity");

    // Return depth stays within the return RAM.
    a_rdepth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rdepth_reg <= RS_CNT_W'(RSTACK_DEPTH))
        else $error("return stack depth beyond capacity");

    // The divider only runs while the sequencer waits for it.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> (state_reg == FSM_DIV))
        else $error("divider busy outside divide wait");

    // A faulting step leaves the stack depth unchanged.
    a_fault_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (status != ST_OK)) |=> $stable(depth_reg))
        else $error("stack depth changed on fault");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the stack machine executor. A directed table of instruction
// words runs first, then random programs that stay legal, and a last stretch
// that drives the block into a stop and on with random words. A result word is
// checked against its typed table row, else against the testbench predictor of the machine.
// ----------------------------------------------------------------------------
module tb_top;

    import sme_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM_A = 500;
    localparam int N_RANDOM_B = 600;
    localparam int SETTLE     = 60;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // func[7:0], operand[39:8]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // next_pc[15:0], status[19:16], top_value[51:20],
                            // stack_depth[60:52], running[61], zero[63:62]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct {
        logic [15:0] pc;
        status_t     st;
        logic [31:0] top;
        logic [8:0]  depth;
        logic        run;
    } step_res_t;

    typedef struct {
        logic [7:0]  func;
        logic [31:0] opd;
        logic        typed;
        logic [15:0] pc;
        status_t     st;
        logic [31:0] top;
        logic [8:0]  depth;
    } dir_row_t;

    // Directed rows with a program length of 65535
    localparam int N_DIR = 26;
    dir_row_t dir_tab [N_DIR] = '{
        '{OP_PUSH,  32'h7FFF_FFFF, 1'b1, 16'd5,   ST_OK, 32'h7FFF_FFFF, 9'd1},
        '{OP_PUSH,  32'h8000_0000, 1'b1, 16'd10,  ST_OK, 32'h8000_0000, 9'd2},
        '{OP_ADD,   32'h0,         1'b1, 16'd11,  ST_OK, 32'hFFFF_FFFF, 9'd1},
        '{OP_PUSH,  32'hFFFF_FFFF, 1'b1, 16'd16,  ST_OK, 32'hFFFF_FFFF, 9'd2},
        '{OP_MUL,   32'h0,         1'b1, 16'd17,  ST_OK, 32'h1,         9'd1},
        '{OP_PUSH,  32'h8000_0000, 1'b1, 16'd22,  ST_OK, 32'h8000_0000, 9'd2},
        '{OP_PUSH,  32'hFFFF_FFFF, 1'b1, 16'd27,  ST_OK, 32'hFFFF_FFFF, 9'd3},
        '{OP_DIV,   32'h0,         1'b1, 16'd28,  ST_OK, 32'h8000_0000, 9'd2},
        '{OP_SWAP,  32'hFFFF_FFFF, 1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_SUB,   32'h0,         1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_PUSH,  32'h0,         1'b1, 16'd35,  ST_OK, 32'h0,         9'd2},
        '{OP_CMP,   32'h0,         1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_DUP,   32'h0,         1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_JZ,    32'd100,       1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_JNZ,   32'hFFFF_FFFF, 1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_PUSH,  32'd5,         1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_STW,   32'd255,       1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_LOAD,  32'd255,       1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_STW,   32'd0,         1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_LOAD,  32'd0,         1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_CALL,  32'd1000,      1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_RET,   32'h0,         1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_PUSH,  32'd12,        1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_DIV,   32'h0,         1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_POP,   32'h0,         1'b0, 16'd0,   ST_OK, 32'h0,         9'd0},
        '{OP_JMP,   32'd65529,     1'b0, 16'd0,   ST_OK, 32'h0,         9'd0}
    };

    // Machine state as the predictor sees it
    int          prog_len;
    int          pc_m;
    logic        run_m;
    logic [31:0] dstk [DSTACK_DEPTH];
    int          dsp;
    logic [15:0] rstk [RSTACK_DEPTH];
    int          rsp;
    logic [31:0] wmem [MEM_WORDS];

    step_res_t   pending_q[$];
    int          mismatches;
    int          idle_cycles;
    logic        quiet = 1'b0;

    stack_machine_executor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic bad_tgt(input logic [31:0] t);
        return $signed(t) < 0 || $signed(t) >= prog_len;
    endfunction

    function automatic logic bad_idx(input logic [31:0] t);
        return $signed(t) < 0 || $signed(t) >= MEM_WORDS;
    endfunction

    // Executes one instruction word on the predictor state.
    task exec_insn(input logic [7:0] f, input logic [31:0] raw, output step_res_t r);
        status_t     st;
        int          npc;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] v;
        logic        take;
        st = ST_OK;
        if (!run_m)
            st = ST_STOPPED;
        else if (pc_m >= prog_len)
        begin
            st = ST_PC_RANGE;
            run_m = 1'b0;
        end
        else
        begin
            npc = pc_m + 1;
            if (f == OP_PUSH || (f >= OP_JMP && f <= OP_CALL))
            begin
                if (npc + 4 > prog_len)
                    st = ST_OPD_END;
                else
                    npc = npc + 4;
            end
            if (st == ST_OK)
            begin
                case (f)
                    OP_HALT: st = ST_HALTED;
                    OP_PUSH:
                        if (dsp >= DSTACK_DEPTH) st = ST_DS_OVER;
                        else
                        begin
                            dstk[dsp] = raw;
                            dsp++;
                        end
                    OP_POP:
                        if (dsp == 0) st = ST_DS_UNDER;
                        else dsp--;
                    OP_DUP:
                        if (dsp == 0) st = ST_DS_UNDER;
                        else if (dsp >= DSTACK_DEPTH) st = ST_DS_OVER;
                        else
                        begin
                            dstk[dsp] = dstk[dsp-1];
                            dsp++;
                        end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP:
                        if (dsp < 2) st = ST_DS_UNDER;
                        else
                        begin
                            b = dstk[dsp-1];
                            a = dstk[dsp-2];
                            v = '0;
                            case (f)
                                OP_ADD: v = a + b;
                                OP_SUB: v = a - b;
                                OP_MUL: v = a * b;
                                OP_DIV:
                                    if (b == 0) st = ST_DIV_ZERO;
                                    else v = 32'(longint'($signed(a)) /
                                                 longint'($signed(b)));
                                default: v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            endcase
                            if (st == ST_OK)
                            begin
                                dstk[dsp-2] = v;
                                dsp--;
                            end
                        end
                    OP_JMP:
                        if (bad_tgt(raw)) st = ST_BAD_TARGET;
                        else npc = int'(raw);
                    OP_JZ, OP_JNZ:
                        if (dsp == 0) st = ST_DS_UNDER;
                        else
                        begin
                            take = (f == OP_JZ) ? (dstk[dsp-1] == 0) : (dstk[dsp-1] != 0);
                            if (take && bad_tgt(raw)) st = ST_BAD_TARGET;
                            else
                            begin
                                dsp--;
                                if (take) npc = int'(raw);
                            end
                        end
                    OP_STW:
                        if (dsp == 0) st = ST_DS_UNDER;
                        else if (bad_idx(raw)) st = ST_BAD_INDEX;
                        else
                        begin
                            dsp--;
                            wmem[raw[7:0]] = dstk[dsp];
                        end
                    OP_LOAD:
                        if (bad_idx(raw)) st = ST_BAD_INDEX;
                        else if (dsp >= DSTACK_DEPTH) st = ST_DS_OVER;
                        else
                        begin
                            dstk[dsp] = wmem[raw[7:0]];
                            dsp++;
                        end
                    OP_CALL:
                        if (bad_tgt(raw)) st = ST_BAD_TARGET;
                        else if (rsp >= RSTACK_DEPTH) st = ST_RS_OVER;
                        else
                        begin
                            rstk[rsp] = npc[15:0];
                            rsp++;
                            npc = int'(raw);
                        end
                    OP_RET:
                        if (rsp == 0) st = ST_RS_UNDER;
                        else
                        begin
                            rsp--;
                            npc = int'(rstk[rsp]);
                        end
                    OP_SWAP:
                        if (dsp < 2) st = ST_DS_UNDER;
                        else
                        begin
                            v = dstk[dsp-1];
                            dstk[dsp-1] = dstk[dsp-2];
                            dstk[dsp-2] = v;
                        end
                    default: st = ST_BAD_OPCODE;
                endcase
            end
            if (st == ST_OK || st == ST_HALTED)
                pc_m = npc & 16'hFFFF;
            if (st != ST_OK)
                run_m = 1'b0;
        end
        r.pc    = pc_m[15:0];
        r.st    = st;
        r.top   = (dsp != 0) ? dstk[dsp-1] : 32'h0;
        r.depth = dsp[8:0];
        r.run   = run_m;
    endtask

    // Picks an instruction that the machine executes without a fault.
    task pick_legal(input logic climb, input logic rclimb,
                    output logic [7:0] f, output logic [31:0] raw);
        logic ok;
        int   tgt;
        int   sel;
        tgt = $urandom_range(0, prog_len - 16);
        ok  = 1'b0;
        if (pc_m > prog_len - 16)
        begin
            f   = OP_JMP;
            raw = $urandom_range(0, 50);
            ok  = 1'b1;
        end
        while (!ok)
        begin
            f = 8'($urandom_range(1, 16));
            if (climb && $urandom_range(0, 2) == 0)
                f = OP_PUSH;
            else if (!climb && $urandom_range(0, 4) == 0)
                f = OP_POP;
            if (rclimb && $urandom_range(0, 5) == 0)
                f = OP_CALL;
            raw = $urandom;
            case (f)
                OP_PUSH:
                begin
                    ok  = dsp < DSTACK_DEPTH;
                    sel = $urandom_range(0, 7);
                    if (sel == 0) raw = 32'h8000_0000;
                    else if (sel == 1) raw = 32'h7FFF_FFFF;
                    else if (sel == 2) raw = 32'd0;
                    else if (sel == 3) raw = 32'($urandom_range(0, 20)) - 32'd10;
                end
                OP_POP, OP_STW: ok = dsp > 0;
                OP_DUP: ok = dsp > 0 && dsp < DSTACK_DEPTH;
                OP_ADD, OP_SUB, OP_MUL, OP_CMP, OP_SWAP: ok = dsp >= 2;
                OP_DIV: ok = dsp >= 2 && dstk[dsp-1] != 0;
                OP_JMP, OP_CALL:
                begin
                    ok  = (f == OP_JMP) || rsp < RSTACK_DEPTH;
                    raw = tgt;
                end
                OP_JZ, OP_JNZ:
                begin
                    ok = dsp > 0;
                    // a branch that is not taken may carry any target
                    if (ok && ((f == OP_JZ) == (dstk[dsp-1] == 0)))
                        raw = tgt;
                end
                OP_LOAD: ok = dsp < DSTACK_DEPTH;
                OP_RET: ok = rsp > 0 && int'(rstk[rsp-1]) <= prog_len - 16;
                default: ok = 1'b0;
            endcase
            if (f == OP_STW || f == OP_LOAD)
                raw = $urandom_range(0, MEM_WORDS - 1);
        end
    endtask

    // Sends one instruction word and queues what it should produce.
    task send_word(input logic [7:0] f, input logic [31:0] raw,
                   input logic typed, input step_res_t fixed);
        step_res_t r;
        int        gap;
        if ($urandom_range(0, 39) == 0)
            quiet = ~quiet;
        gap = quiet ? 0 : $urandom_range(0, 16);
        repeat (gap) @(negedge clk);
        s_tdata  = {raw, f};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        exec_insn(f, raw, r);
        pending_q.push_back(typed ? fixed : r);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Register write once the machine has gone quiet.
    task write_reg(input logic [2:0] addr, input logic [31:0] val);
        wait (pending_q.size() == 0);
        repeat (SETTLE) @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == 3'd0)
            prog_len = int'(val[15:0]);
    endtask

    task run_random(input int count);
        logic [7:0]  f;
        logic [31:0] raw;
        logic        climb;
        logic        rclimb;
        step_res_t   none;
        none   = '{pc: '0, st: ST_OK, top: '0, depth: '0, run: 1'b0};
        climb  = 1'b1;
        rclimb = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 79) == 0) climb = ~climb;
            if ($urandom_range(0, 79) == 0) rclimb = ~rclimb;
            pick_legal(climb, rclimb, f, raw);
            send_word(f, raw, 1'b0, none);
        end
    endtask

    // Result checker
    initial
    begin
        step_res_t e;
        step_res_t got;
        int        gap;
        m_tready = 1'b0;
        forever
        begin
            gap = quiet ? 0 : $urandom_range(0, 16);
            repeat (gap) @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.pc    = m_tdata[15:0];
            got.st    = status_t'(m_tdata[19:16]);
            got.top   = m_tdata[51:20];
            got.depth = m_tdata[60:52];
            got.run   = m_tdata[61];
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", m_tdata);
            end
            else
            begin
                e = pending_q.pop_front();
                if (got.pc !== e.pc || got.st !== e.st || got.top !== e.top ||
                    got.depth !== e.depth || got.run !== e.run || m_tdata[63:62] !== 2'b0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp pc %0d st %0d top %h depth %0d run %0b,",
                                  " got pc %0d st %0d top %h depth %0d run %0b"},
                                 e.pc, e.st, e.top, e.depth, e.run,
                                 got.pc, got.st, got.top, got.depth, got.run);
                end
            end
            @(negedge clk);
            m_tready = 1'b0;
        end
    end

    // Watchdog on cycles with no word moved on any port
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        step_res_t   fixed;
        logic [7:0]  f;
        logic [31:0] raw;
        int          n;
        int          kind;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mismatches  = 0;
        prog_len    = 0;
        pc_m        = 0;
        run_m       = 1'b1;
        dsp         = 0;
        rsp         = 0;
        for (int i = 0; i < MEM_WORDS; i++)
            wmem[i] = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed table at the largest program length
        write_reg(3'd0, 32'hFFFF);
        for (int i = 0; i < N_DIR; i++)
        begin
            fixed = '{dir_tab[i].pc, dir_tab[i].st, dir_tab[i].top,
                      dir_tab[i].depth, 1'b1};
            send_word(dir_tab[i].func, dir_tab[i].opd, dir_tab[i].typed, fixed);
        end

        // Random legal programs, first long then short
        run_random(N_RANDOM_A);
        send_word(OP_JMP, 32'($urandom_range(0, 40)), 1'b0, fixed);
        write_reg(3'd0, 32'($urandom_range(64, 1024)));
        run_random(N_RANDOM_B);

        // Drive the machine into a stop, then keep feeding it
        kind = $urandom_range(0, 3);
        if (kind == 0)
            write_reg(3'd0, 32'd0);
        else if (kind == 1)
            write_reg(3'd0, 32'(pc_m + 3));
        n = 0;
        while (run_m && n < 200)
        begin
            f   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 16));
            raw = ($urandom_range(0, 1) == 0) ? $urandom
                                              : 32'($urandom_range(0, 300)) - 32'd20;
            send_word(f, raw, 1'b0, fixed);
            n++;
        end
        for (int i = 0; i < 20; i++)
            send_word(8'($urandom_range(0, 255)), $urandom, 1'b0, fixed);

        wait (pending_q.size() == 0);
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sme_pkg.sv
rtl/sme_ram.sv
rtl/sme_divider.sv
rtl/stack_machine_executor.sv
tb/tb_top.sv
